FILE: hw/rtl/vsq_pkg.sv
// ----------------------------------------------------------------------------
// vsq_pkg: valve inrush sequencer types and constants
// Request and result payloads, sequencer and valve phase codes, register
// indexes and reset values shared by the sequencer RTL.
// ----------------------------------------------------------------------------
package vsq_pkg;

	localparam int unsigned VEC_W       = 12;
	localparam int unsigned IDX_FIELD_W = 4;
	localparam int unsigned CNT_W       = 16;
	localparam int unsigned QPOS_W      = 5;
	localparam int unsigned CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_INRUSH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_DELAY = 2'd1;

	localparam logic [CNT_W-1:0]  INRUSH_RST    = 16'd60;
	localparam logic [CNT_W-1:0]  OFF_DELAY_RST = 16'd120;
	localparam logic [QPOS_W-1:0] QPOS_MAX      = 5'd31;
	localparam logic [QPOS_W-1:0] QPOS_ONE      = 5'd1;
	localparam logic [QPOS_W-1:0] QPOS_TWO      = 5'd2;

	localparam logic ACT_TICK    = 1'b0;
	localparam logic ACT_COMMAND = 1'b1;

	typedef struct packed {
		logic                   action;
		logic [IDX_FIELD_W-1:0] valve_index;
		logic                   wanted_on;
	} vsq_req_t;

	typedef struct packed {
		logic [VEC_W-1:0] drive_bits;
		logic [VEC_W-1:0] status_bits;
	} vsq_rsp_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_WALK,
		SEQ_DONE
	} vsq_seq_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ENABLE,
		PH_ASSERTED,
		PH_DISABLE
	} vsq_phase_t;

endpackage

FILE: hw/rtl/valve_inrush_sequencer_top.sv
// ----------------------------------------------------------------------------
// valve_inrush_sequencer_top: inrush-limited valve sequencer
// Commands set one valve's wanted state; ticks walk every valve through its
// phase machine, one valve per cycle through a shared counter decrementer.
// A command gives its result strobe in the cycle after acceptance; a tick gives
// it once the walk has visited every valve. Throughput: one command per cycle
// when no tick walk runs; busy holds off requests during a walk, and a new
// request is taken in the cycle the result is shown. Results cannot be stalled.
// Reset clears all valve state at once; registers return to 60 and 120 ticks.
// ----------------------------------------------------------------------------
module valve_inrush_sequencer_top
	import vsq_pkg::*;
#(
	parameter int unsigned NUM_VALVES = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  vsq_req_t                          req,
	output logic                              done,
	output vsq_rsp_t                          rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [CFG_IDX_W-1:0]              cfg_index,
	input  logic [CNT_W-1:0]                  cfg_data
);

	localparam int unsigned IDX_W = (NUM_VALVES > 1) ? $clog2(NUM_VALVES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VALVES - 1);

	vsq_seq_t                state_q, state_d;
	logic [IDX_W-1:0]        idx_q;
	logic [NUM_VALVES-1:0]   wanted_q, drive_q, status_q;
	vsq_phase_t              phase_q [NUM_VALVES];
	logic [QPOS_W-1:0]       qpos_q [NUM_VALVES];
	logic [CNT_W-1:0]        off_cnt_q [NUM_VALVES];
	logic [CNT_W-1:0]        inrush_q;
	logic                    open_busy_q;
	logic [QPOS_W-1:0]       next_q_q;
	logic [CNT_W-1:0]        inrush_ticks_q, off_ticks_q;

	logic                    accept, cmd_ok;
	logic [IDX_W-1:0]        cmd_idx;

	logic                    v_w, v_d;
	vsq_phase_t              v_ph, n_ph;
	logic [QPOS_W-1:0]       v_pos, n_pos;
	logic [CNT_W-1:0]        v_oc, n_oc;
	logic                    n_drive, n_status, n_busy, shift;
	logic [CNT_W-1:0]        n_inrush;
	logic [QPOS_W-1:0]       n_next_q;
	logic [CNT_W-1:0]        dec_src, dec_val;
	logic                    dec_zero;

	logic [VEC_W+NUM_VALVES-1:0] drive_ext, status_ext;
	logic [NUM_VALVES-1:0]       asserted_vec;

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign cmd_ok    = ({1'b0, req.valve_index} < (IDX_FIELD_W + 1)'(NUM_VALVES));
	assign cmd_idx   = req.valve_index[IDX_W-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE, SEQ_DONE: begin
				if (accept) begin
					state_d = (req.action == ACT_COMMAND) ? SEQ_DONE : SEQ_WALK;
				end else begin
					state_d = SEQ_IDLE;
				end
			end
			SEQ_WALK: begin
				if (idx_q == LAST_IDX) begin
					state_d = SEQ_DONE;
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q == SEQ_WALK);
		done = (state_q == SEQ_DONE);
	end

	assign drive_ext       = {{VEC_W{1'b0}}, drive_q};
	assign status_ext      = {{VEC_W{1'b0}}, status_q};
	assign rsp.drive_bits  = drive_ext[VEC_W-1:0];
	assign rsp.status_bits = status_ext[VEC_W-1:0];

	// shared decrementer: inrush counter in asserted phase, off counter otherwise
	always_comb begin
		v_w      = wanted_q[idx_q];
		v_d      = drive_q[idx_q];
		v_ph     = phase_q[idx_q];
		v_pos    = qpos_q[idx_q];
		v_oc     = off_cnt_q[idx_q];
		dec_src  = (v_ph == PH_ASSERTED) ? inrush_q : v_oc;
		dec_zero = (dec_src == '0);
		dec_val  = dec_src - CNT_W'(1);

		n_ph     = v_ph;
		n_pos    = v_pos;
		n_oc     = v_oc;
		n_drive  = v_d;
		n_status = status_q[idx_q];
		n_busy   = open_busy_q;
		n_inrush = inrush_q;
		n_next_q = next_q_q;
		shift    = 1'b0;

		case (v_ph)
			PH_IDLE: begin
				if (v_d != v_w && v_w) begin
					n_status = 1'b1;
					n_ph     = PH_ENABLE;
				end else if (v_d != v_w) begin
					n_status = 1'b0;
					n_ph     = PH_DISABLE;
				end else begin
					n_status = v_d;
				end
			end
			PH_ENABLE: begin
				if (v_d == v_w) begin
					n_pos = '0;
					shift = 1'b1;
					n_ph  = PH_IDLE;
				end else if (open_busy_q && v_pos == '0) begin
					n_pos = next_q_q;
					if (next_q_q < QPOS_MAX) begin
						n_next_q = next_q_q + QPOS_ONE;
					end
				end else if (!open_busy_q && v_pos < QPOS_TWO) begin
					n_pos   = '0;
					n_drive = 1'b1;
					n_busy  = 1'b1;
					n_ph    = PH_ASSERTED;
				end
			end
			PH_ASSERTED: begin
				if (dec_zero || (v_d && !v_w)) begin
					if (!dec_zero) begin
						n_drive = 1'b0;
					end
					n_busy   = 1'b0;
					n_inrush = inrush_ticks_q;
					shift    = 1'b1;
					n_ph     = PH_IDLE;
				end else begin
					n_inrush = dec_val;
					n_busy   = 1'b1;
				end
			end
			PH_DISABLE: begin
				if (dec_zero) begin
					n_drive = 1'b0;
					n_oc    = off_ticks_q;
					n_ph    = PH_IDLE;
				end else if (v_d && v_w) begin
					n_drive = 1'b1;
					n_oc    = off_ticks_q;
					n_ph    = PH_IDLE;
				end else begin
					n_oc = dec_val;
				end
			end
			default: n_ph = PH_IDLE;
		endcase

		if (shift && next_q_q > QPOS_ONE) begin
			n_next_q = next_q_q - QPOS_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= SEQ_IDLE;
			idx_q          <= '0;
			wanted_q       <= '0;
			drive_q        <= '0;
			status_q       <= '0;
			inrush_q       <= INRUSH_RST;
			open_busy_q    <= 1'b0;
			next_q_q       <= QPOS_ONE;
			inrush_ticks_q <= INRUSH_RST;
			off_ticks_q    <= OFF_DELAY_RST;
			for (int k = 0; k < NUM_VALVES; k++) begin
				phase_q[k]   <= PH_IDLE;
				qpos_q[k]    <= '0;
				off_cnt_q[k] <= OFF_DELAY_RST;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_INRUSH) begin
					inrush_ticks_q <= cfg_data;
				end else if (cfg_index == CFG_OFF_DELAY) begin
					off_ticks_q <= cfg_data;
				end
			end
			if (accept) begin
				idx_q <= '0;
				if (req.action == ACT_COMMAND && cmd_ok) begin
					wanted_q[cmd_idx] <= req.wanted_on;
					status_q[cmd_idx] <= req.wanted_on;
				end
			end
			if (state_q == SEQ_WALK) begin
				idx_q              <= idx_q + IDX_W'(1);
				phase_q[idx_q]     <= n_ph;
				off_cnt_q[idx_q]   <= n_oc;
				drive_q[idx_q]     <= n_drive;
				status_q[idx_q]    <= n_status;
				inrush_q           <= n_inrush;
				open_busy_q        <= n_busy;
				next_q_q           <= n_next_q;
				for (int k = 0; k < NUM_VALVES; k++) begin
					if (IDX_W'(k) == idx_q) begin
						qpos_q[k] <= n_pos;
					end else if (shift && qpos_q[k] != '0) begin
						qpos_q[k] <= qpos_q[k] - QPOS_ONE;
					end
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_VALVES; k++) begin
			asserted_vec[k] = (phase_q[k] == PH_ASSERTED);
		end
	end

	a_one_opener: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(asserted_vec) <= 1)
		else $error("more than one valve in inrush window");

	a_opener_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(asserted_vec != '0) |-> open_busy_q)
		else $error("valve asserted without opening busy");

	a_next_q_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_q_q != '0)
		else $error("next queue number reached zero");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(accept) && $past(req.action == ACT_COMMAND))
			|| ($past(busy) && $past(idx_q == LAST_IDX)))
		else $error("result strobe without a finished request");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (idx_q <= LAST_IDX))
		else $error("walk index out of range");

endmodule
